/* rtl/fpe_pkg.sv */
// ============================================================================
// fpe_pkg - shared types and constants for frustum plane extraction
// Field widths, unit opcodes and the request struct that the sequencer
// sends to the shared arithmetic unit.
// ============================================================================
package fpe_pkg;

    // Default fraction width of the fixed-point format
    localparam int FRAC_BITS_DEF = 16;

    // Field widths
    localparam int VALUE_W = 32;          // matrix element / coefficient
    localparam int INDEX_W = 4;           // matrix store address
    localparam int PLANE_W = 3;           // plane number
    localparam int MAT_DEPTH = 16;        // 4x4 matrix

    // Internal widths: row sum/difference magnitude, sum of three squares
    localparam int MAG_W = VALUE_W + 1;
    localparam int SUM_W = 2 * MAG_W;

    // Plane sequencing
    localparam int NUM_COEF = 4;
    localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(5);
    // Bit p set: plane p is row 3 plus the selected row, else row 3 minus it
    localparam logic [5:0] ROW_ADD = 6'b100110;

    // Saturation limits
    localparam logic [VALUE_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] COEF_MIN = 32'h8000_0000;

    // Shared unit operations
    typedef enum logic [1:0] {
        OP_SQUARE = 2'd0,
        OP_SQRT   = 2'd1,
        OP_DIV    = 2'd2
    } fpe_op_t;

    // Request from the sequencer to the shared unit
    typedef struct packed {
        logic    start;
        fpe_op_t op;
    } fpe_unit_req_t;

endpackage

/* rtl/fpe_if.sv */
// ============================================================================
// fpe_if - valid/ready channels of the frustum plane extractor
// One channel for matrix element loads, one for normalized plane results.
// ============================================================================
interface fpe_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [fpe_pkg::VALUE_W-1:0] element_value;
    logic [fpe_pkg::INDEX_W-1:0]     element_index;
    logic                            is_last;

    modport source (
        output valid, element_value, element_index, is_last,
        input  ready
    );
    modport sink (
        input  valid, element_value, element_index, is_last,
        output ready
    );
endinterface

interface fpe_out_if;
    logic                            valid;
    logic                            ready;
    logic [fpe_pkg::PLANE_W-1:0]     plane_index;
    logic signed [fpe_pkg::VALUE_W-1:0] coef_a;
    logic signed [fpe_pkg::VALUE_W-1:0] coef_b;
    logic signed [fpe_pkg::VALUE_W-1:0] coef_c;
    logic signed [fpe_pkg::VALUE_W-1:0] coef_d;
    logic                            degenerate;
    logic                            last_plane;

    modport source (
        output valid, plane_index, coef_a, coef_b, coef_c, coef_d,
               degenerate, last_plane,
        input  ready
    );
    modport sink (
        input  valid, plane_index, coef_a, coef_b, coef_c, coef_d,
               degenerate, last_plane,
        output ready
    );
endinterface

/* rtl/fpe_store.sv */
// ============================================================================
// fpe_store - 16 x 32 matrix store
// One write port, two registered read ports (row 3 and the selected row).
// ============================================================================
module fpe_store (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [fpe_pkg::INDEX_W-1:0]   wr_addr,
    input  logic [fpe_pkg::VALUE_W-1:0]   wr_data,
    input  logic [fpe_pkg::INDEX_W-1:0]   rd_addr_a,
    input  logic [fpe_pkg::INDEX_W-1:0]   rd_addr_b,
    output logic [fpe_pkg::VALUE_W-1:0]   rd_data_a,
    output logic [fpe_pkg::VALUE_W-1:0]   rd_data_b
);
    import fpe_pkg::*;

    logic [VALUE_W-1:0] mem [MAT_DEPTH];
    logic [VALUE_W-1:0] rd_a_reg;
    logic [VALUE_W-1:0] rd_b_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read ports
    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

/* rtl/fpe_unit.sv */
// ============================================================================
// fpe_unit - shared iterative arithmetic unit
// One add/subtract datapath stepped once per cycle: shift-add square,
// restoring integer square root (two radicand bits a step) and restoring
// division (one quotient bit a step). done is registered and pulses in the
// cycle after the last step; results hold until the next start.
// ============================================================================
module fpe_unit #(
    parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fpe_pkg::fpe_unit_req_t                req,
    input  logic [fpe_pkg::MAG_W-1:0]             mag,
    input  logic [fpe_pkg::SUM_W-1:0]             radicand,
    input  logic [fpe_pkg::MAG_W-1:0]             divisor,
    output logic                                  done,
    output logic [fpe_pkg::SUM_W-1:0]             product,
    output logic [fpe_pkg::MAG_W-1:0]             root,
    output logic [fpe_pkg::MAG_W+FRAC_BITS-1:0]   quotient
);
    import fpe_pkg::*;

    localparam int DIV_W = MAG_W + FRAC_BITS;
    localparam int SH_W  = (SUM_W > DIV_W) ? SUM_W : DIV_W;
    localparam int CNT_W = $clog2(DIV_W);
    localparam int HI_W  = MAG_W + 2;
    localparam int ALU_W = HI_W + 1;

    // Control
    fpe_op_t           op_reg,   op_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;

    // Datapath
    logic [MAG_W-1:0]  mcand_reg, mcand_next;
    logic [HI_W-1:0]   hi_reg,    hi_next;
    logic [SH_W-1:0]   sh_reg,    sh_next;
    logic [DIV_W-1:0]  q_reg,     q_next;

    logic [ALU_W-1:0]  alu_a;
    logic [ALU_W-1:0]  alu_b;
    logic              alu_sub;
    logic [ALU_W:0]    alu_sum;
    logic              keep;

    // Shared adder: operand selection by operation
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (op_reg)
            OP_SQUARE:
            begin
                alu_a = ALU_W'(hi_reg[HI_W-2:0]);
                alu_b = sh_reg[0] ? ALU_W'(mcand_reg) : '0;
            end
            OP_SQRT:
            begin
                alu_a   = ALU_W'({hi_reg[MAG_W-1:0], sh_reg[SH_W-1 -: 2]});
                alu_b   = ALU_W'({q_reg[MAG_W-1:0], 2'b01});
                alu_sub = 1'b1;
            end
            OP_DIV:
            begin
                alu_a   = ALU_W'({hi_reg[MAG_W-1:0], sh_reg[SH_W-1]});
                alu_b   = ALU_W'(mcand_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
        alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {ALU_W{alu_sub}}}
                + (ALU_W+1)'(alu_sub);
        // carry out on a subtract: no borrow, trial value fits
        keep = alu_sum[ALU_W];
    end

    // Load on start, otherwise one step per busy cycle
    always_comb
    begin
        op_next    = op_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        if (req.start)
        begin
            op_next   = req.op;
            busy_next = 1'b1;
            hi_next   = '0;
            q_next    = '0;
            case (req.op)
                OP_SQUARE:
                begin
                    mcand_next = mag;
                    sh_next    = SH_W'(mag);
                    cnt_next   = CNT_W'(MAG_W - 1);
                end
                OP_SQRT:
                begin
                    mcand_next = '0;
                    sh_next    = SH_W'(radicand) << (SH_W - SUM_W);
                    cnt_next   = CNT_W'(SUM_W / 2 - 1);
                end
                OP_DIV:
                begin
                    mcand_next = divisor;
                    sh_next    = SH_W'({mag, {FRAC_BITS{1'b0}}}) << (SH_W - DIV_W);
                    cnt_next   = CNT_W'(DIV_W - 1);
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_SQUARE:
                begin
                    // product shifts right through hi:sh
                    hi_next = {1'b0, alu_sum[HI_W-1:1]};
                    sh_next[MAG_W-1:0] = {alu_sum[0], sh_reg[MAG_W-1:1]};
                end
                OP_SQRT:
                begin
                    hi_next = keep ? alu_sum[HI_W-1:0] : alu_a[HI_W-1:0];
                    q_next  = {q_reg[DIV_W-2:0], keep};
                    sh_next = sh_reg << 2;
                end
                OP_DIV:
                begin
                    hi_next = keep ? alu_sum[HI_W-1:0] : alu_a[HI_W-1:0];
                    q_next  = {q_reg[DIV_W-2:0], keep};
                    sh_next = sh_reg << 1;
                end
                default:
                begin
                    hi_next = hi_reg;
                end
            endcase
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_SQUARE;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            op_reg   <= op_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        sh_reg    <= sh_next;
        q_reg     <= q_next;
    end

    assign done     = done_reg;
    assign product  = {hi_reg[MAG_W-1:0], sh_reg[MAG_W-1:0]};
    assign root     = q_reg[MAG_W-1:0];
    assign quotient = q_reg;

endmodule

/* rtl/frustum_plane_extract.sv */
// ============================================================================
// frustum_plane_extract - clip plane extraction from a view-projection matrix
// Loads a column-major 4x4 fixed-point matrix and emits six normalized
// clip planes (right, left, bottom, top, far, near) after the last element.
// ============================================================================
// A load request is taken whenever the block is idle. A load
// marked last starts a run that emits six planes; while a run is in flight
// the load channel is not ready. Every square, the square root and the four
// divisions of a plane go through one shared unit that retires one step per
// cycle; that unit and any wait on result ready set the run length. A plane
// with a zero-length normal skips the root and the divisions.
// Coefficients are signed Q(31-FRAC_BITS).FRAC_BITS, truncated and saturated.
// ============================================================================
module frustum_plane_extract #(
    parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    fpe_in_if.sink     load,
    fpe_out_if.source  result
);
    import fpe_pkg::*;

    localparam int DIV_W = MAG_W + FRAC_BITS;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'h001,
        ST_FETCH_A   = 10'h002,
        ST_FETCH_D   = 10'h004,
        ST_SQ_GO     = 10'h008,
        ST_SQ_WAIT   = 10'h010,
        ST_SQRT_GO   = 10'h020,
        ST_SQRT_WAIT = 10'h040,
        ST_DIV_GO    = 10'h080,
        ST_DIV_WAIT  = 10'h100,
        ST_EMIT      = 10'h200
    } state_t;

    // Control
    state_t              state_reg, state_next;
    logic [PLANE_W-1:0]  plane_reg, plane_next;
    logic [1:0]          idx_reg,   idx_next;

    // Datapath
    logic [MAG_W-1:0]    comp_reg [NUM_COEF];
    logic [MAG_W-1:0]    comp_next [NUM_COEF];
    logic [SUM_W-1:0]    sum_reg,   sum_next;
    logic [MAG_W-1:0]    len_reg,   len_next;
    logic [VALUE_W-1:0]  coef_reg [NUM_COEF];
    logic [VALUE_W-1:0]  coef_next [NUM_COEF];
    logic                degen_reg, degen_next;

    // Store and unit connections
    logic                load_fire;
    logic [INDEX_W-1:0]  rd_addr_w;
    logic [INDEX_W-1:0]  rd_addr_v;
    logic [VALUE_W-1:0]  rd_data_w;
    logic [VALUE_W-1:0]  rd_data_v;
    fpe_unit_req_t       unit_req;
    logic                unit_done;
    logic [SUM_W-1:0]    unit_product;
    logic [MAG_W-1:0]    unit_root;
    logic [DIV_W-1:0]    unit_quot;

    logic                row_add;
    logic [MAG_W-1:0]    w_ext;
    logic [MAG_W-1:0]    v_ext;
    logic [MAG_W-1:0]    comp_new;
    logic [MAG_W-1:0]    cur_comp;
    logic [MAG_W-1:0]    cur_mag;
    logic [SUM_W-1:0]    sum_new;
    logic                quot_over;
    logic [VALUE_W-1:0]  coef_new;

    assign load_fire = load.valid & load.ready;

    fpe_store u_store (
        .clk       (clk),
        .wr_en     (load_fire),
        .wr_addr   (load.element_index),
        .wr_data   (load.element_value),
        .rd_addr_a (rd_addr_w),
        .rd_addr_b (rd_addr_v),
        .rd_data_a (rd_data_w),
        .rd_data_b (rd_data_v)
    );

    fpe_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (unit_req),
        .mag      (cur_mag),
        .radicand (sum_reg),
        .divisor  (len_reg),
        .done     (unit_done),
        .product  (unit_product),
        .root     (unit_root),
        .quotient (unit_quot)
    );

    // Row 3 and the plane's row of the current column
    assign rd_addr_w = {idx_reg, 2'b11};
    assign rd_addr_v = {idx_reg, plane_reg[2:1]};
    assign row_add   = ROW_ADD[plane_reg];

    // Row sum/difference, magnitude, square sum, saturated quotient
    always_comb
    begin
        w_ext    = {rd_data_w[VALUE_W-1], rd_data_w};
        v_ext    = {rd_data_v[VALUE_W-1], rd_data_v};
        comp_new = row_add ? (w_ext + v_ext) : (w_ext - v_ext);
        cur_comp = comp_reg[idx_reg];
        cur_mag  = cur_comp[MAG_W-1] ? (~cur_comp + MAG_W'(1)) : cur_comp;
        sum_new  = sum_reg + unit_product;
        quot_over = |unit_quot[DIV_W-1:VALUE_W-1];
        if (cur_comp[MAG_W-1])
        begin
            coef_new = quot_over ? COEF_MIN : (~unit_quot[VALUE_W-1:0] + VALUE_W'(1));
        end
        else
        begin
            coef_new = quot_over ? COEF_MAX : unit_quot[VALUE_W-1:0];
        end
    end

    // Unit request
    always_comb
    begin
        unit_req.start = 1'b0;
        unit_req.op    = OP_DIV;
        case (state_reg)
            ST_SQ_GO:
            begin
                unit_req.start = 1'b1;
                unit_req.op    = OP_SQUARE;
            end
            ST_SQRT_GO:
            begin
                unit_req.start = 1'b1;
                unit_req.op    = OP_SQRT;
            end
            ST_DIV_GO:
            begin
                unit_req.start = 1'b1;
                unit_req.op    = OP_DIV;
            end
            default:
            begin
                unit_req.start = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        plane_next = plane_reg;
        idx_next   = idx_reg;
        comp_next  = comp_reg;
        sum_next   = sum_reg;
        len_next   = len_reg;
        coef_next  = coef_reg;
        degen_next = degen_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load_fire && load.is_last)
                begin
                    plane_next = '0;
                    idx_next   = '0;
                    state_next = ST_FETCH_A;
                end
            end
            ST_FETCH_A:
            begin
                state_next = ST_FETCH_D;
            end
            ST_FETCH_D:
            begin
                comp_next[idx_reg] = comp_new;
                if (idx_reg == 2'd3)
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = ST_SQ_GO;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_FETCH_A;
                end
            end
            ST_SQ_GO:
            begin
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                if (unit_done)
                begin
                    sum_next = sum_new;
                    if (idx_reg == 2'd2)
                    begin
                        idx_next = '0;
                        if (sum_new == '0)
                        begin
                            // zero-length normal: flag and zero the plane
                            degen_next = 1'b1;
                            for (int i = 0; i < NUM_COEF; i++)
                            begin
                                coef_next[i] = '0;
                            end
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            degen_next = 1'b0;
                            state_next = ST_SQRT_GO;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_SQ_GO;
                    end
                end
            end
            ST_SQRT_GO:
            begin
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (unit_done)
                begin
                    len_next   = unit_root;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (unit_done)
                begin
                    coef_next[idx_reg] = coef_new;
                    if (idx_reg == 2'd3)
                    begin
                        idx_next   = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_EMIT:
            begin
                if (result.ready)
                begin
                    idx_next = '0;
                    if (plane_reg == LAST_PLANE)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        plane_next = plane_reg + PLANE_W'(1);
                        state_next = ST_FETCH_A;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            plane_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            plane_reg <= plane_next;
            idx_reg   <= idx_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        comp_reg  <= comp_next;
        sum_reg   <= sum_next;
        len_reg   <= len_next;
        coef_reg  <= coef_next;
        degen_reg <= degen_next;
    end

    // Channel outputs
    assign load.ready         = (state_reg == ST_IDLE);
    assign result.valid       = (state_reg == ST_EMIT);
    assign result.plane_index = plane_reg;
    assign result.coef_a      = $signed(coef_reg[0]);
    assign result.coef_b      = $signed(coef_reg[1]);
    assign result.coef_c      = $signed(coef_reg[2]);
    assign result.coef_d      = $signed(coef_reg[3]);
    assign result.degenerate  = degen_reg;
    assign result.last_plane  = (plane_reg == LAST_PLANE);

    // Loads are never taken while a plane is on offer
    a_no_load_during_emit: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |-> !load.ready
    ) else $error("load ready while a plane is on offer");

    // A degenerate plane carries all-zero coefficients
    a_degen_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && result.degenerate) |->
            (result.coef_a == '0 && result.coef_b == '0 &&
             result.coef_c == '0 && result.coef_d == '0)
    ) else $error("degenerate plane with nonzero coefficients");

    // The shared unit only finishes while the sequencer waits on it
    a_done_in_wait: assert property (
        @(posedge clk) disable iff (!rst_n)
        unit_done |-> (state_reg == ST_SQ_WAIT || state_reg == ST_SQRT_WAIT ||
                       state_reg == ST_DIV_WAIT)
    ) else $error("unit finished outside a wait state");

    // Taking the sixth plane ends the run
    a_run_end: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.last_plane) |=> load.ready
    ) else $error("block not idle after the last plane");

endmodule
